@@ sv/dex_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dex_pkg
// Shared types, constants and helpers of the downward expander.
// ----------------------------------------------------------------------------
package dex_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned MulW     = 33;
  localparam int unsigned ProdW    = 2 * MulW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RATIO     = 2'd1,
    REG_ATTACK    = 2'd2,
    REG_RELEASE   = 2'd3
  } cfg_reg_e;

  localparam logic signed [16:0] ThresholdRst = -17'sd7680;
  localparam logic [12:0]        RatioRst     = 13'd512;
  localparam logic [15:0]        AttackRst    = 16'd65388;
  localparam logic [15:0]        ReleaseRst   = 16'd65521;

  localparam logic signed [16:0] LevelFloor = -17'sd51200;
  localparam logic signed [15:0] EnvMin     = -16'sd20480;
  localparam logic [18:0]        DbPerLog2  = 19'd394566;   // 20*log10(2), Q16
  localparam logic [21:0]        Log2PerDb  = 22'd2786635;  // log2(10)/20, Q24

  typedef logic [15:0][31:0] root_tbl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = v;
    r   = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q2.30 chain of repeated square roots of one half
  function automatic root_tbl_t root_table();
    root_tbl_t   tbl;
    logic [63:0] t;
    t = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      t      = isqrt64(t << 30);
      tbl[k] = t[31:0];
    end
    return tbl;
  endfunction

  localparam root_tbl_t RootTbl = root_table();

  // arithmetic right shift, rounding half away from zero
  function automatic logic signed [ProdW-1:0] rnd_shr(input logic signed [ProdW-1:0] v,
                                                      input int unsigned s);
    logic signed [ProdW-1:0] half;
    logic signed [ProdW-1:0] bias;
    half = $signed({{(ProdW-1){1'b0}}, 1'b1} << (s - 1));
    bias = v[ProdW-1] ? half - 1 : half;
    return (v + bias) >>> s;
  endfunction

endpackage
`default_nettype wire

@@ sv/dex_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dex_if
// Handshake channels of the downward expander: sample in, result out, config.
// ----------------------------------------------------------------------------
interface dex_in_if #(parameter int unsigned W = 24) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface dex_out_if #(parameter int unsigned W = 24) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  logic signed [15:0]  gain_db;
  modport source (output valid, output sample_out, output gain_db, input ready);
  modport sink   (input valid, input sample_out, input gain_db, output ready);
endinterface

interface dex_cfg_if import dex_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/dex_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dex_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module dex_mul import dex_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic signed [MulW-1:0]  a_i,
  input  wire logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0]      prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

@@ sv/downward_expander_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// downward_expander_unit
// Downward expander with attack/release smoothed gain.
//
// in_i carries one signed sample per transfer; out_o returns the expanded
// sample and the smoothed gain in Q8.8 dB. cfg_i writes threshold, ratio,
// attack and release registers; it is always ready and must only be used
// while the unit is idle.
// One shared multiplier serves the steps after a bit-serial normalize: 16
// squaring steps for log2, level, target, smoother and dB-to-log2 steps,
// 16 root-chain steps for the linear gain and the final scale. A zero
// sample skips the normalize, log2 and level steps. in_i.ready stays low
// from the transfer until the result is registered.
// The result sits in an output register; the next sample is accepted while
// it waits, and the unit stalls in its last step only if the previous result
// has still not been taken.
// Reset restores register defaults and a 0 dB envelope; nothing is pending.
// ----------------------------------------------------------------------------
module downward_expander_unit import dex_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dex_in_if.sink     in_i,
  dex_out_if.source  out_o,
  dex_cfg_if.sink    cfg_i
);

  localparam int unsigned SB = SAMPLE_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_SQR, S_SQR2, S_LVL, S_LVL2, S_TGT, S_TGT2,
    S_SMOOTH, S_SMOOTH2, S_EXP, S_EXP2, S_GAIN, S_GAIN2, S_SCALE, S_MULX, S_OUT
  } state_e;

  state_e state_q;

  logic signed [16:0]    thr_q;
  logic [12:0]           ratio_q;
  logic [15:0]           att_q;
  logic [15:0]           rel_q;

  logic signed [SB-1:0]  x_q;
  logic [31:0]           y_q;
  logic [4:0]            e_q;
  logic [15:0]           frac_q;
  logic [3:0]            k_q;
  logic signed [16:0]    lvl_q;
  logic signed [23:0]    tgt_q;
  logic signed [15:0]    env_q;
  logic [4:0]            ip_q;
  logic [15:0]           fp_q;
  logic [30:0]           g_q;

  logic                  out_valid_q;
  logic signed [SB-1:0]  out_sample_q;
  logic signed [15:0]    out_gain_q;

  logic signed [MulW-1:0]  mul_a;
  logic signed [MulW-1:0]  mul_b;
  logic signed [ProdW-1:0] prod;

  logic [SB-1:0]           mag;
  logic signed [6:0]       lhi;
  logic signed [22:0]      lval;
  logic [21:0]             lneg;
  logic [15:0]             coef;
  logic signed [24:0]      ediff;
  logic [32:0]             sq;
  logic signed [ProdW-1:0] sum;
  logic signed [ProdW-1:0] env_r;
  logic signed [ProdW-1:0] e2;
  logic [20:0]             pmag;
  logic [31:0]             g_shr;
  logic signed [ProdW-1:0] y_r;
  logic                    out_free;

  dex_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.gain_db    = out_gain_q;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    mag   = in_i.sample_in[SB-1] ? SB'(-in_i.sample_in) : in_i.sample_in;
    lhi   = $signed({2'b00, e_q}) - 7'(SB - 1);
    lval  = {lhi, frac_q};
    lneg  = 22'(-lval);
    coef  = ($signed(tgt_q) < $signed(24'(env_q))) ? att_q : rel_q;
    ediff = 25'(env_q) - 25'(tgt_q);
    sq    = prod[63:31];
    sum   = (ProdW'(tgt_q) <<< 16) + prod;
    env_r = rnd_shr(sum, 16);
    e2    = rnd_shr(prod, 16);
    pmag  = e2[ProdW-1] ? 21'(-e2) : '0;
    g_shr = (32'(g_q) >> (ip_q - 5'd1)) + 32'd1;
    y_r   = rnd_shr(prod, 30);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQR: begin
        mul_a = $signed({1'b0, y_q});
        mul_b = $signed({1'b0, y_q});
      end
      S_LVL: begin
        mul_a = $signed(MulW'(lneg));
        mul_b = $signed(MulW'(DbPerLog2));
      end
      S_TGT: begin
        mul_a = MulW'(18'(thr_q) - 18'(lvl_q));
        mul_b = MulW'($signed(14'd256) - $signed({1'b0, ratio_q}));
      end
      S_SMOOTH: begin
        mul_a = $signed(MulW'(coef));
        mul_b = MulW'(ediff);
      end
      S_EXP: begin
        mul_a = MulW'(env_q);
        mul_b = $signed(MulW'(Log2PerDb));
      end
      S_GAIN: begin
        mul_a = $signed(MulW'(g_q));
        mul_b = $signed(MulW'(RootTbl[k_q]));
      end
      S_MULX, S_OUT: begin
        mul_a = MulW'(x_q);
        mul_b = $signed(MulW'(g_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      thr_q        <= ThresholdRst;
      ratio_q      <= RatioRst;
      att_q        <= AttackRst;
      rel_q        <= ReleaseRst;
      env_q        <= '0;
      out_valid_q  <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
      e_q          <= '0;
      frac_q       <= '0;
      k_q          <= '0;
      lvl_q        <= '0;
      tgt_q        <= '0;
      ip_q         <= '0;
      fp_q         <= '0;
      g_q          <= '0;
      out_sample_q <= '0;
      out_gain_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_THRESHOLD: thr_q   <= $signed(cfg_i.data);
          REG_RATIO:     ratio_q <= cfg_i.data[12:0];
          REG_ATTACK:    att_q   <= cfg_i.data[15:0];
          REG_RELEASE:   rel_q   <= cfg_i.data[15:0];
          default:       ;
        endcase
      end

      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            x_q    <= in_i.sample_in;
            y_q    <= 32'(mag);
            e_q    <= 5'd31;
            frac_q <= '0;
            k_q    <= '0;
            if (mag == '0) begin
              lvl_q   <= LevelFloor;
              state_q <= S_TGT;
            end else begin
              state_q <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (y_q[31]) begin
            state_q <= S_SQR;
          end else begin
            y_q <= y_q << 1;
            e_q <= e_q - 5'd1;
          end
        end
        S_SQR: state_q <= S_SQR2;
        S_SQR2: begin
          frac_q <= {frac_q[14:0], sq[32]};
          y_q    <= sq[32] ? sq[32:1] : sq[31:0];
          k_q    <= k_q + 4'd1;
          state_q <= (k_q == 4'd15) ? S_LVL : S_SQR;
        end
        S_LVL: begin
          if (!lval[22]) begin
            lvl_q   <= '0;
            state_q <= S_TGT;
          end else begin
            state_q <= S_LVL2;
          end
        end
        S_LVL2: begin
          lvl_q   <= 17'(-((prod + ProdW'(64'd1 << 23)) >>> 24));
          state_q <= S_TGT;
        end
        S_TGT: begin
          if (lvl_q < thr_q) begin
            state_q <= S_TGT2;
          end else begin
            tgt_q   <= '0;
            state_q <= S_SMOOTH;
          end
        end
        S_TGT2: begin
          tgt_q   <= 24'(rnd_shr(prod, 8));
          state_q <= S_SMOOTH;
        end
        S_SMOOTH: state_q <= S_SMOOTH2;
        S_SMOOTH2: begin
          if (env_r > 0) begin
            env_q <= '0;
          end else if (env_r < ProdW'(EnvMin)) begin
            env_q <= EnvMin;
          end else begin
            env_q <= 16'(env_r);
          end
          state_q <= S_EXP;
        end
        S_EXP: state_q <= S_EXP2;
        S_EXP2: begin
          ip_q    <= 5'(pmag[20:16]);
          fp_q    <= pmag[15:0];
          g_q     <= 31'd1 << 30;
          k_q     <= '0;
          state_q <= S_GAIN;
        end
        S_GAIN: state_q <= S_GAIN2;
        S_GAIN2: begin
          if (fp_q[4'd15 - k_q]) begin
            g_q <= 31'((prod + ProdW'(64'd1 << 29)) >>> 30);
          end
          k_q     <= k_q + 4'd1;
          state_q <= (k_q == 4'd15) ? S_SCALE : S_GAIN;
        end
        S_SCALE: begin
          if (ip_q != '0) begin
            g_q <= 31'(g_shr >> 1);
          end
          state_q <= S_MULX;
        end
        S_MULX: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_sample_q <= SB'(y_r);
            out_gain_q   <= env_q;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (env_q <= 16'sd0) && (env_q >= EnvMin))
    else $error("envelope out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("accepted a sample while busy");

  a_result_from_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the final step");

  a_gain_matches_env: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_gain_q == env_q))
    else $error("reported gain differs from envelope");
`endif

endmodule
`default_nettype wire
